// File: rtl/multi_level_priority_fifo_core_macros.svh
// Assertion macros shared by the checker of the multi-level priority FIFO.
`ifndef MULTI_LEVEL_PRIORITY_FIFO_CORE_MACROS_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MLPF_ASSERT_NOW(label, cond, prop) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
	else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MLPF_ASSERT_NEXT(label, cond, prop) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
	else $error("next-cycle check failed");

`endif

// File: rtl/mlpf_pkg.sv
// Shared types and codes of the multi-level priority FIFO.
`default_nettype none
package mlpf_pkg;
	localparam logic [1:0] ACT_ENQ       = 2'd0;
	localparam logic [1:0] ACT_DEQ_EXACT = 2'd1;
	localparam logic [1:0] ACT_DEQ_MIN   = 2'd2;
	localparam logic [1:0] ACT_DEQ_ANY   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int GROUP = 16;

	typedef struct packed {
		logic       found;
		logic [7:0] level;
	} mlpf_find_t;
endpackage
`default_nettype wire

// File: rtl/multi_level_priority_fifo_core.sv
// Top level of the multi-level priority FIFO: sequencer, bitmap and free-entry control.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------------
//  command   | action, level, payload                  | start high while busy is low
//  result    | status, out_payload, served_level       | done high for one cycle
//
// One transaction is taken at a time and busy stays high until its result is issued.
// A rejected enqueue (store full or level out of range) or a dequeue-exact from an
// empty or out-of-range level returns its result in the cycle after acceptance
// without going busy. An enqueue reads the level pointers and the free-stack link,
// then writes back. A search dequeue runs the bitmap search through a two-stage
// registered encoder; each dequeue then reads the level pointers and the store
// entry one after the other, each memory through a registered read port.
// Reset is asynchronous and active low; no clearing pass is needed, since entries that
// were never handed out are counted by a fill register rather than chained in memory.
// The receiver cannot stall, so done is asserted exactly once per transaction.
`default_nettype none
module multi_level_priority_fifo_core #(
	parameter int LEVELS        = 256,
	parameter int CAPACITY      = 256,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  level,
	input  wire logic [31:0] payload,
	output logic             done,
	output logic      [1:0]  status,
	output logic      [31:0] out_payload,
	output logic      [7:0]  served_level
);
	localparam int LW = $clog2(LEVELS);
	localparam int EW = $clog2(CAPACITY);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ENQ  = 3'd1;
	localparam logic [2:0] S_F1   = 3'd2;
	localparam logic [2:0] S_F2   = 3'd3;
	localparam logic [2:0] S_F3   = 3'd4;
	localparam logic [2:0] S_DPTR = 3'd5;
	localparam logic [2:0] S_DENT = 3'd6;

	logic [2:0]  state_q, state_d;
	logic [1:0]  act_q;
	logic [7:0]  lvl_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [LW-1:0] sel_q, sel_d;
	logic [LEVELS-1:0] bitmap_q, bitmap_d;
	logic [EW:0] used_q, used_d;
	// Entries below fresh_q have been handed out at least once; the rest are unused.
	logic [EW:0] fresh_q, fresh_d;
	// Head of the stack of entries that were freed by dequeues.
	logic [EW-1:0] rec_head_q, rec_head_d;
	logic [EW-1:0] h_q;
	logic last_q;

	logic done_d;
	logic [1:0] status_d;
	logic [31:0] outpay_d;
	logic [7:0] served_d;

	logic lv_re, en_re;
	logic [LW-1:0] lv_raddr, lv_waddr;
	logic [EW-1:0] lv_head_rd, lv_tail_rd, lv_wdata;
	logic lv_head_we, lv_tail_we;
	logic [EW-1:0] en_raddr, en_next_rd, en_next_waddr, en_next_wdata, en_pay_waddr;
	logic [PAYLOAD_WIDTH-1:0] en_pay_rd;
	logic en_next_we, en_pay_we;

	logic [7:0] find_start;
	mlpf_pkg::mlpf_find_t find_res;

	logic in_range, is_full, use_fresh, lvl_busy;
	logic [EW-1:0] new_e;

	assign find_start = (act_q == mlpf_pkg::ACT_DEQ_ANY) ? 8'd0 : lvl_q;
	assign in_range   = {1'b0, level} < 9'(LEVELS);
	assign is_full    = used_q == (EW+1)'(CAPACITY);
	assign use_fresh  = fresh_q != (EW+1)'(CAPACITY);
	assign new_e      = use_fresh ? fresh_q[EW-1:0] : rec_head_q;
	assign lvl_busy   = bitmap_q[lvl_q[LW-1:0]];

	always_comb begin
		state_d    = state_q;
		sel_d      = sel_q;
		bitmap_d   = bitmap_q;
		used_d     = used_q;
		fresh_d    = fresh_q;
		rec_head_d = rec_head_q;
		done_d     = 1'b0;
		status_d   = mlpf_pkg::ST_NONE;
		outpay_d   = 32'd0;
		served_d   = 8'd0;
		lv_re      = 1'b0;
		lv_raddr   = level[LW-1:0];
		lv_head_we = 1'b0;
		lv_tail_we = 1'b0;
		lv_waddr   = lvl_q[LW-1:0];
		lv_wdata   = new_e;
		en_re      = 1'b0;
		en_raddr   = rec_head_q;
		en_next_we = 1'b0;
		en_next_waddr = lv_tail_rd;
		en_next_wdata = new_e;
		en_pay_we  = 1'b0;
		en_pay_waddr = new_e;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (action)
						mlpf_pkg::ACT_ENQ: begin
							if (!in_range || is_full) begin
								done_d   = 1'b1;
								status_d = mlpf_pkg::ST_FULL;
								served_d = level;
							end else begin
								// Tail pointer of the level and the free-stack link.
								lv_re   = 1'b1;
								en_re   = 1'b1;
								state_d = S_ENQ;
							end
						end
						mlpf_pkg::ACT_DEQ_EXACT: begin
							if (in_range && bitmap_q[level[LW-1:0]]) begin
								lv_re   = 1'b1;
								sel_d   = level[LW-1:0];
								state_d = S_DPTR;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							state_d = S_F1;
						end
					endcase
				end
			end
			S_ENQ: begin
				en_pay_we  = 1'b1;
				en_next_we = lvl_busy;
				lv_head_we = !lvl_busy;
				lv_tail_we = 1'b1;
				bitmap_d[lvl_q[LW-1:0]] = 1'b1;
				used_d = used_q + 1'b1;
				if (use_fresh) begin
					fresh_d = fresh_q + 1'b1;
				end else begin
					rec_head_d = en_next_rd;
				end
				done_d   = 1'b1;
				status_d = mlpf_pkg::ST_DONE;
				served_d = lvl_q;
				state_d  = S_IDLE;
			end
			S_F1: begin
				state_d = S_F2;
			end
			S_F2: begin
				state_d = S_F3;
			end
			S_F3: begin
				if (find_res.found) begin
					lv_re    = 1'b1;
					lv_raddr = find_res.level[LW-1:0];
					sel_d    = find_res.level[LW-1:0];
					state_d  = S_DPTR;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DPTR: begin
				en_re    = 1'b1;
				en_raddr = lv_head_rd;
				state_d  = S_DENT;
			end
			S_DENT: begin
				// Unlink the front entry and push it onto the free stack.
				if (last_q) begin
					bitmap_d[sel_q] = 1'b0;
				end else begin
					lv_head_we = 1'b1;
				end
				lv_waddr      = sel_q;
				lv_wdata      = en_next_rd;
				en_next_we    = 1'b1;
				en_next_waddr = h_q;
				en_next_wdata = rec_head_q;
				rec_head_d    = h_q;
				used_d        = used_q - 1'b1;
				done_d        = 1'b1;
				status_d      = mlpf_pkg::ST_DONE;
				outpay_d      = 32'(en_pay_rd);
				served_d      = 8'(sel_q);
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bitmap_q   <= '0;
			used_q     <= '0;
			fresh_q    <= '0;
			rec_head_q <= '0;
			done_q_rst: begin
				done <= 1'b0;
			end
		end else begin
			state_q    <= state_d;
			bitmap_q   <= bitmap_d;
			used_q     <= used_d;
			fresh_q    <= fresh_d;
			rec_head_q <= rec_head_d;
			done       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= action;
			lvl_q <= level;
			pay_q <= PAYLOAD_WIDTH'(payload);
		end
		if (state_q == S_DPTR) begin
			h_q    <= lv_head_rd;
			last_q <= lv_head_rd == lv_tail_rd;
		end
		sel_q <= sel_d;
		if (done_d) begin
			status       <= status_d;
			out_payload  <= outpay_d;
			served_level <= served_d;
		end
	end

	assign busy = state_q != S_IDLE;

	mlpf_level_store #(
		.LEVELS (LEVELS),
		.EW     (EW)
	) u_level (
		.clk     (clk),
		.re      (lv_re),
		.raddr   (lv_raddr),
		.head_rd (lv_head_rd),
		.tail_rd (lv_tail_rd),
		.head_we (lv_head_we),
		.tail_we (lv_tail_we),
		.waddr   (lv_waddr),
		.wdata   (lv_wdata)
	);

	mlpf_entry_store #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
		.EW            (EW)
	) u_entry (
		.clk        (clk),
		.re         (en_re),
		.raddr      (en_raddr),
		.next_rd    (en_next_rd),
		.pay_rd     (en_pay_rd),
		.next_we    (en_next_we),
		.next_waddr (en_next_waddr),
		.next_wdata (en_next_wdata),
		.pay_we     (en_pay_we),
		.pay_waddr  (en_pay_waddr),
		.pay_wdata  (pay_q)
	);

	mlpf_find #(
		.LEVELS (LEVELS)
	) u_find (
		.clk         (clk),
		.arst_n      (arst_n),
		.bitmap      (bitmap_q),
		.start_level (find_start),
		.result      (find_res)
	);
endmodule
`default_nettype wire

// File: rtl/mlpf_level_store.sv
// Per-level head and tail pointer memories with one registered read port.
`default_nettype none
module mlpf_level_store #(
	parameter int LEVELS = 256,
	parameter int EW     = 8
) (
	input  wire logic                      clk,
	input  wire logic                      re,
	input  wire logic [$clog2(LEVELS)-1:0] raddr,
	output logic      [EW-1:0]             head_rd,
	output logic      [EW-1:0]             tail_rd,
	input  wire logic                      head_we,
	input  wire logic                      tail_we,
	input  wire logic [$clog2(LEVELS)-1:0] waddr,
	input  wire logic [EW-1:0]             wdata
);
	logic [EW-1:0] head_mem [LEVELS];
	logic [EW-1:0] tail_mem [LEVELS];

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[waddr] <= wdata;
		end
		if (tail_we) begin
			tail_mem[waddr] <= wdata;
		end
		if (re) begin
			head_rd <= head_mem[raddr];
			tail_rd <= tail_mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/mlpf_entry_store.sv
// Shared linked store: next-pointer and payload memories, one registered read port.
`default_nettype none
module mlpf_entry_store #(
	parameter int CAPACITY      = 256,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int EW            = 8
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic [EW-1:0]            raddr,
	output logic      [EW-1:0]            next_rd,
	output logic      [PAYLOAD_WIDTH-1:0] pay_rd,
	input  wire logic                     next_we,
	input  wire logic [EW-1:0]            next_waddr,
	input  wire logic [EW-1:0]            next_wdata,
	input  wire logic                     pay_we,
	input  wire logic [EW-1:0]            pay_waddr,
	input  wire logic [PAYLOAD_WIDTH-1:0] pay_wdata
);
	logic [EW-1:0]            next_mem [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] pay_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (pay_we) begin
			pay_mem[pay_waddr] <= pay_wdata;
		end
		if (re) begin
			next_rd <= next_mem[raddr];
			pay_rd  <= pay_mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/mlpf_find.sv
// Two-stage registered find-first over the non-empty bitmap, from a start level up.
`default_nettype none
module mlpf_find #(
	parameter int LEVELS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [LEVELS-1:0] bitmap,
	input  wire logic [7:0]        start_level,
	output mlpf_pkg::mlpf_find_t   result
);
	localparam int G  = mlpf_pkg::GROUP;
	localparam int NG = (LEVELS + G - 1) / G;

	logic [NG*G-1:0] masked;
	logic [NG-1:0]   any_s1;
	logic [3:0]      first_s1 [NG];
	logic [3:0]      first_c  [NG];
	mlpf_pkg::mlpf_find_t pick_c;

	// Keep only levels at or above the start level.
	always_comb begin
		masked = '0;
		for (int i = 0; i < LEVELS; i++) begin
			masked[i] = bitmap[i] && (9'(i) >= {1'b0, start_level});
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			first_c[g] = 4'd0;
			for (int j = G - 1; j >= 0; j--) begin
				if (masked[g*G + j]) begin
					first_c[g] = 4'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
		end else begin
			for (int g = 0; g < NG; g++) begin
				any_s1[g] <= |masked[g*G +: G];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			first_s1[g] <= first_c[g];
		end
	end

	always_comb begin
		pick_c = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				pick_c.found = 1'b1;
				pick_c.level = {4'(g), first_s1[g]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result <= '0;
		end else begin
			result <= pick_c;
		end
	end
endmodule
`default_nettype wire

// File: rtl/mlpf_checker.sv
// Port-level checker of the multi-level priority FIFO and its bind to the top level.
`default_nettype none
`include "multi_level_priority_fifo_core_macros.svh"
module mlpf_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  action,
	input wire logic [7:0]  level,
	input wire logic [31:0] payload,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] out_payload,
	input wire logic [7:0]  served_level
);
	`MLPF_ASSERT_NOW(a_status_code, done, status != 2'd3)
	`MLPF_ASSERT_NOW(a_none_zero, done && status == mlpf_pkg::ST_NONE, out_payload == 32'd0 && served_level == 8'd0)
	`MLPF_ASSERT_NOW(a_enq_no_payload, done && status == mlpf_pkg::ST_FULL, out_payload == 32'd0)
	`MLPF_ASSERT_NEXT(a_full_level, start && !busy && action == mlpf_pkg::ACT_ENQ, busy || (done && served_level == $past(level)))
endmodule

bind multi_level_priority_fifo_core mlpf_port_checker u_mlpf_checker (.*);
`default_nettype wire
